@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file tcs_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ rtl/tcs_pkg.sv @@
// Shared types, constants and helpers for the triangle setup and cull core.
// No dependencies.
package tcs_pkg;

    typedef logic signed [31:0] q16_t;

    localparam int DVD_W    = 48;              // divider dividend width
    localparam int DIV_STEPS = DVD_W;          // one quotient bit per stage
    localparam int NORM_W   = DVD_W + 1;       // signed normalized value
    localparam int LANE_LAT = DIV_STEPS + 3;   // load, steps, scale, offset
    localparam int VERTS    = 3;
    localparam int SCR_W    = 14;

    localparam logic [SCR_W-1:0] WIDTH_RESET  = 14'd800;
    localparam logic [SCR_W-1:0] HEIGHT_RESET = 14'd600;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_VISIBLE = 2'd0,
        VERDICT_OUTSIDE = 2'd1,
        VERDICT_BACK    = 2'd2
    } verdict_t;

    typedef struct packed {
        q16_t a_x; q16_t a_y; q16_t a_z; q16_t a_w;
        q16_t b_x; q16_t b_y; q16_t b_z; q16_t b_w;
        q16_t c_x; q16_t c_y; q16_t c_z; q16_t c_w;
    } in_word_t;

    typedef struct packed {
        logic [1:0] verdict;
        q16_t sa_x; q16_t sa_y; q16_t sa_z;
        q16_t sb_x; q16_t sb_y; q16_t sb_z;
        q16_t sc_x; q16_t sc_y; q16_t sc_z;
        logic signed [63:0] twice_area;
    } out_word_t;

    // Per-stage control carried along the pipeline.
    typedef struct packed {
        logic vld;
        logic rej;
    } tcs_ctl_t;

    function automatic q16_t sat32(input logic signed [63:0] v);
        q16_t r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [63:0] sat64(input logic signed [66:0] v);
        logic signed [63:0] r;
        if (v > $signed({3'b000, 64'h7FFFFFFFFFFFFFFF}))
            r = 64'sh7FFFFFFFFFFFFFFF;
        else if (v < $signed({3'b111, 64'h8000000000000000}))
            r = 64'sh8000000000000000;
        else
            r = v[63:0];
        return r;
    endfunction

endpackage

@@ rtl/tcs_div.sv @@
// Pipelined restoring divider: (v * 2^16) / w, truncated toward zero.
// Depends on tcs_pkg.
module tcs_div
    import tcs_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  q16_t                     v,
    input  q16_t                     w,
    output logic signed [NORM_W-1:0] q
);

    logic [31:0]      rem_reg [0:DIV_STEPS];
    logic [DVD_W-1:0] acc_reg [0:DIV_STEPS];
    logic [31:0]      dsr_reg [0:DIV_STEPS];
    logic             neg_reg [0:DIV_STEPS];
    logic [31:0]      mag_v;
    logic [31:0]      mag_w;
    logic             w_zero;

    assign mag_v  = v[31] ? 32'(-v) : 32'(v);
    assign mag_w  = w[31] ? 32'(-w) : 32'(w);
    assign w_zero = (w == '0);

    // A zero w leaves the value undivided: divide the raw magnitude by one.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            acc_reg[0] <= w_zero ? {16'd0, mag_v} : {mag_v, 16'd0};
            dsr_reg[0] <= w_zero ? 32'd1 : mag_w;
            neg_reg[0] <= v[31] ^ w[31];
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        logic [32:0] r2;
        logic [32:0] trial;
        logic        ge;

        assign r2    = {rem_reg[s], acc_reg[s][DVD_W-1]};
        assign trial = r2 - {1'b0, dsr_reg[s]};
        assign ge    = !trial[32];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= ge ? trial[31:0] : r2[31:0];
                acc_reg[s+1] <= {acc_reg[s][DVD_W-2:0], ge};
                dsr_reg[s+1] <= dsr_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    assign q = neg_reg[DIV_STEPS] ? -$signed({1'b0, acc_reg[DIV_STEPS]})
                                  :  $signed({1'b0, acc_reg[DIV_STEPS]});

endmodule

@@ rtl/tcs_lane.sv @@
// One vertex lane: perspective divide of x, y, z and viewport mapping.
// Depends on tcs_pkg and tcs_div.
module tcs_lane
    import tcs_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  q16_t             x,
    input  q16_t             y,
    input  q16_t             z,
    input  q16_t             w,
    input  logic [SCR_W-1:0] scr_w,
    input  logic [SCR_W-1:0] scr_h,
    output q16_t             sx,
    output q16_t             sy,
    output q16_t             sz
);

    logic signed [NORM_W-1:0] nx, ny, nz;
    logic signed [63:0]       px_reg, py_reg;
    q16_t                     z1_reg;
    q16_t                     sx_reg, sy_reg, sz_reg;
    logic signed [63:0]       offx, offy;

    tcs_div u_div_x (.clk(clk), .en(en), .v(x), .w(w), .q(nx));
    tcs_div u_div_y (.clk(clk), .en(en), .v(y), .w(w), .q(ny));
    tcs_div u_div_z (.clk(clk), .en(en), .v(z), .w(w), .q(nz));

    assign offx = $signed({35'd0, scr_w[SCR_W-1:1], 16'd0});
    assign offy = $signed({35'd0, scr_h[SCR_W-1:1], 16'd0});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= 64'(nx * $signed({1'b0, scr_w}));
            py_reg <= 64'(ny * $signed({1'b0, scr_h}));
            z1_reg <= sat32(64'(nz));
            sx_reg <= sat32(offx + (px_reg >>> 1));
            sy_reg <= sat32(offy - (py_reg >>> 1));
            sz_reg <= z1_reg;
        end
    end

    assign sx = sx_reg;
    assign sy = sy_reg;
    assign sz = sz_reg;

endmodule

@@ rtl/tcs_merge.sv @@
// Merge stage: signed area of the three lanes, verdict and output register.
// Depends on tcs_pkg.
module tcs_merge
    import tcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  tcs_ctl_t  ctl,
    input  q16_t      sx [VERTS],
    input  q16_t      sy [VERTS],
    input  q16_t      sz [VERTS],
    output logic      out_valid,
    output out_word_t out_data
);

    tcs_ctl_t           ctl_a_reg, ctl_b_reg;
    logic               valid_reg;
    logic signed [32:0] d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [65:0] p_reg, q_reg;
    q16_t               sxa_reg [VERTS], sya_reg [VERTS], sza_reg [VERTS];
    q16_t               sxb_reg [VERTS], syb_reg [VERTS], szb_reg [VERTS];
    out_word_t          word_reg, word_next;
    logic signed [63:0] area;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl;
            ctl_b_reg <= ctl_a_reg;
            valid_reg <= ctl_b_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg   <= 33'(sx[2]) - 33'(sx[0]);
            d2_reg   <= 33'(sy[1]) - 33'(sy[0]);
            d3_reg   <= 33'(sy[2]) - 33'(sy[0]);
            d4_reg   <= 33'(sx[1]) - 33'(sx[0]);
            p_reg    <= d1_reg * d2_reg;
            q_reg    <= d3_reg * d4_reg;
            sxa_reg  <= sx;
            sya_reg  <= sy;
            sza_reg  <= sz;
            sxb_reg  <= sxa_reg;
            syb_reg  <= sya_reg;
            szb_reg  <= sza_reg;
            word_reg <= word_next;
        end
    end

    assign area = sat64(67'(p_reg) - 67'(q_reg));

    always_comb
    begin
        word_next = '0;
        if (ctl_b_reg.rej)
        begin
            word_next.verdict = VERDICT_OUTSIDE;
        end
        else
        begin
            word_next.verdict    = area[63] ? VERDICT_BACK : VERDICT_VISIBLE;
            word_next.sa_x       = sxb_reg[0];
            word_next.sa_y       = syb_reg[0];
            word_next.sa_z       = szb_reg[0];
            word_next.sb_x       = sxb_reg[1];
            word_next.sb_y       = syb_reg[1];
            word_next.sb_z       = szb_reg[1];
            word_next.sc_x       = sxb_reg[2];
            word_next.sc_y       = syb_reg[2];
            word_next.sc_z       = szb_reg[2];
            word_next.twice_area = area;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = word_reg;

endmodule

@@ rtl/triangle_setup_cull_core.sv @@
// Triangle setup and cull: frustum reject, perspective divide, viewport map,
// signed area and back-face cull. One triangle per cycle unless stalled.
// The three 48-stage divider pipelines per lane dominate the latency; the whole
// pipe advances together and holds only while the output word is stalled.
// Reset clears all valid bits and loads screen size 800 x 600.
// Depends on tcs_pkg, tcs_lane and tcs_merge.
module triangle_setup_cull_core
    import tcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_data,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SCR_W-1:0] width_reg, height_reg;
    logic             adv;
    tcs_ctl_t         ctl_reg [LANE_LAT];
    logic             reject;
    q16_t             vx [VERTS], vy [VERTS], vz [VERTS], vw [VERTS];
    q16_t             sx [VERTS], sy [VERTS], sz [VERTS];
    logic [VERTS-1:0] xg, xl, yg, yl, zn;

    // Configuration registers; the user writes them only while the pipe is empty (not enforced by the block).
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {18'd0, height_reg} : {18'd0, width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_WIDTH)
                width_reg <= pwdata[SCR_W-1:0];
            else
                height_reg <= pwdata[SCR_W-1:0];
        end
    end

    // Advance every stage together unless the output word is held.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    assign vx = '{in_data.a_x, in_data.b_x, in_data.c_x};
    assign vy = '{in_data.a_y, in_data.b_y, in_data.c_y};
    assign vz = '{in_data.a_z, in_data.b_z, in_data.c_z};
    assign vw = '{in_data.a_w, in_data.b_w, in_data.c_w};

    // Frustum test on side planes and z below zero, exact in 33 bits.
    always_comb
    begin
        for (int i = 0; i < VERTS; i++)
        begin
            xg[i] = 33'(vx[i]) >  33'(vw[i]);
            xl[i] = 33'(vx[i]) < -33'(vw[i]);
            yg[i] = 33'(vy[i]) >  33'(vw[i]);
            yl[i] = 33'(vy[i]) < -33'(vw[i]);
            zn[i] = vz[i][31];
        end
        reject = (&xg) || (&xl) || (&yg) || (&yl) || (&zn);
    end

    // Valid and reject flags ride alongside the lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LANE_LAT; s++)
                ctl_reg[s] <= '0;
        end
        else if (adv)
        begin
            ctl_reg[0].vld <= in_valid;
            ctl_reg[0].rej <= reject;
            for (int s = 1; s < LANE_LAT; s++)
                ctl_reg[s] <= ctl_reg[s-1];
        end
    end

    for (genvar i = 0; i < VERTS; i++)
    begin : g_lane
        tcs_lane u_lane (
            .clk   (clk),
            .en    (adv),
            .x     (vx[i]),
            .y     (vy[i]),
            .z     (vz[i]),
            .w     (vw[i]),
            .scr_w (width_reg),
            .scr_h (height_reg),
            .sx    (sx[i]),
            .sy    (sy[i]),
            .sz    (sz[i])
        );
    end

    tcs_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .ctl       (ctl_reg[LANE_LAT-1]),
        .sx        (sx),
        .sy        (sy),
        .sz        (sz),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

@@ rtl/tcs_checker.sv @@
// Port-level checks for the triangle setup and cull core, bound to the top.
// Depends on tcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcs_checker
    import tcs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_data
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `ASSERT_SAME(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall)
    `ASSERT_SAME(a_outside_zero, clk, rst_n, out_valid && out_data.verdict == VERDICT_OUTSIDE, out_data.twice_area == 64'sd0 && out_data.sa_x == 32'sd0)
    `ASSERT_SAME(a_back_neg, clk, rst_n, out_valid && out_data.verdict == VERDICT_BACK, out_data.twice_area < 64'sd0)

endmodule

bind triangle_setup_cull_core tcs_checker u_tcs_checker (.*);
